[rtl/json_string_escaper_defines.svh]
// Assertion macros for the JSON string escaper.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define JSE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("json_string_escaper: check failed");

// Next-cycle implication, checked out of reset
`define JSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("json_string_escaper: check failed");

`endif

[rtl/jse_pkg.sv]
// Package for the JSON string escaper: descriptor types, character codes
// and the classify / run length / hex digit functions. No dependencies.
`timescale 1ns / 1ps

package jse_pkg;

  // Character codes
  localparam logic [7:0] ChrBslash = 8'h5C;
  localparam logic [7:0] ChrQuote  = 8'h22;
  localparam logic [7:0] ChrU      = 8'h75;
  localparam logic [7:0] ChrZero   = 8'h30;
  localparam logic [7:0] ChrOne    = 8'h31;
  localparam logic [7:0] ChrLowA   = 8'h61;
  localparam logic [7:0] CtrlLimit = 8'h20;

  // Escape kinds
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,  // byte unchanged
    KIND_SHORT = 2'd1,  // backslash + one character
    KIND_UNI   = 2'd2   // backslash u 0 0 h h
  } jse_kind_e;

  // Run length and byte position within a run
  localparam int unsigned RunMax = 6;
  localparam int unsigned IdxW   = $clog2(RunMax);

  // One classified input byte, as queued between front and back
  typedef struct packed {
    jse_kind_e  kind;
    logic [7:0] data;    // raw byte, or escape character for KIND_SHORT
    logic       str_end;
  } jse_desc_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } jse_qstat_t;

  function automatic jse_desc_t jse_classify(input logic [7:0] b, input logic str_end);
    jse_desc_t d;
    d.str_end = str_end;
    d.kind    = KIND_SHORT;
    d.data    = b;
    unique case (b)
      ChrQuote, ChrBslash: d.data = b;
      8'h08:               d.data = 8'h62;  // b
      8'h0C:               d.data = 8'h66;  // f
      8'h0A:               d.data = 8'h6E;  // n
      8'h0D:               d.data = 8'h72;  // r
      8'h09:               d.data = 8'h74;  // t
      default: begin
        d.kind = (b < CtrlLimit) ? KIND_UNI : KIND_PASS;
      end
    endcase
    return d;
  endfunction

  function automatic logic [IdxW-1:0] jse_last_idx(input jse_kind_e kind);
    logic [IdxW-1:0] r;
    unique case (kind)
      KIND_SHORT: r = IdxW'(1);
      KIND_UNI:   r = IdxW'(RunMax - 1);
      default:    r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] jse_hex(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = ChrZero + {4'd0, n};
    end else begin
      r = ChrLowA + {4'd0, n - 4'd10};
    end
    return r;
  endfunction

endpackage

[rtl/jse_front.sv]
// Front end: accepts input beats and classifies each byte into a descriptor.
// Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_front
  import jse_pkg::*;
(
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,
  input  logic       s_tlast_i,
  input  logic       q_ready_i,
  output logic       q_push_o,
  output jse_desc_t  q_desc_o
);

  // Accept whenever the queue has room
  assign s_tready_o = q_ready_i;
  assign q_push_o   = s_tvalid_i & q_ready_i;

  // Classify the byte
  always_comb begin
    q_desc_o = jse_classify(s_tdata_i, s_tlast_i);
  end

endmodule

[rtl/jse_queue.sv]
// Small FIFO of classified descriptors between the front and back ends.
// Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_queue
  import jse_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       wr_ready_o,
  input  jse_desc_t  wr_desc_i,
  output logic       rd_valid_o,
  input  logic       pop_i,
  output jse_desc_t  rd_desc_o,
  output jse_qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  jse_desc_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign wr_ready_o   = (cnt_q != CntFull);
  assign rd_valid_o   = (cnt_q != '0);
  assign rd_desc_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = ~wr_ready_o;
  assign stat_o.empty = ~rd_valid_o;

  assign do_push = push_i & wr_ready_o;
  assign do_pop  = pop_i & rd_valid_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_desc_i;
    end
  end

endmodule

[rtl/jse_back.sv]
// Back end: walks each queued descriptor one output byte per beat into a
// registered output stage. Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_back
  import jse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_pop_o,
  input  jse_desc_t  q_desc_i,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,
  output logic       m_tlast_o,
  output logic       m_tuser_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            vld_q, vld_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic            done_q, done_d;
  logic            load, at_last;
  logic [7:0]      cur_byte;

  // Output register is free or being drained
  assign load    = ~vld_q | m_tready_i;
  assign at_last = (idx_q == jse_last_idx(q_desc_i.kind));
  assign q_pop_o = load & q_valid_i & at_last;

  // Byte at the current run position
  always_comb begin
    unique case (idx_q)
      IdxW'(0): cur_byte = (q_desc_i.kind == KIND_PASS) ? q_desc_i.data : ChrBslash;
      IdxW'(1): cur_byte = (q_desc_i.kind == KIND_SHORT) ? q_desc_i.data : ChrU;
      IdxW'(2), IdxW'(3): cur_byte = ChrZero;
      IdxW'(4): cur_byte = jse_hex(q_desc_i.data[7:4]);
      IdxW'(5): cur_byte = jse_hex(q_desc_i.data[3:0]);
      default:  cur_byte = ChrZero;
    endcase
  end

  // Sequencer and output stage next values
  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    last_d = last_q;
    done_d = done_q;
    if (load) begin
      vld_d = q_valid_i;
      if (q_valid_i) begin
        byte_d = cur_byte;
        last_d = at_last;
        done_d = at_last & q_desc_i.str_end;
        idx_d  = at_last ? '0 : idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = byte_q;
  assign m_tlast_o  = last_q;
  assign m_tuser_o  = done_q;

endmodule

[rtl/json_string_escaper.sv]
// JSON string escaper top level: front classifier, descriptor queue, back
// serializer. Depends on jse_pkg, jse_front, jse_queue, jse_back and the defines header.
//
//   channel  dir  beat fields (tdata low bit up | tlast | tuser)
//   s_axis   in   in_byte[7:0]                  | string_end | -
//   m_axis   out  out_byte[7:0]                 | run_last   | string_done
//
// Each input byte yields 1, 2 or 6 output beats; output runs at one beat per cycle
// unless m_axis_tready_i stalls, so throughput is 1 byte/cycle for plain text and
// 1/2 or 1/6 for escapes. An accepted byte enters the queue, then the output register.
// The back end's beat counter sets the rate; the queue lets input keep flowing
// during an expansion until it fills, then s_axis_tready_o drops.
// Reset is asynchronous, active low, and empties queue and output stage.
`timescale 1ns / 1ps
`include "json_string_escaper_defines.svh"

module json_string_escaper
  import jse_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // string_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // run_last
  output logic       m_axis_tuser_o    // [0] string_done
);

  logic       q_push, q_ready, q_valid, q_pop;
  jse_desc_t  wr_desc, rd_desc;
  jse_qstat_t q_stat;

  jse_front u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_desc_o   (wr_desc)
  );

  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .wr_ready_o (q_ready),
    .wr_desc_i  (wr_desc),
    .rd_valid_o (q_valid),
    .pop_i      (q_pop),
    .rd_desc_o  (rd_desc),
    .stat_o     (q_stat)
  );

  jse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_desc_i   (rd_desc),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

  // String end only ever lands on the last beat of a run
  `JSE_ASSERT_IMPL(a_done_on_last, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o)
  // Inner beats of an escape run are backslash, u, or the digits 0 and 1
  `JSE_ASSERT_IMPL(a_inner_bytes, m_axis_tvalid_o && !m_axis_tlast_o, m_axis_tdata_o == ChrBslash || m_axis_tdata_o == ChrU || m_axis_tdata_o == ChrZero || m_axis_tdata_o == ChrOne)
  // Queue status stays consistent
  `JSE_ASSERT_IMPL(a_queue_stat, 1'b1, !(q_stat.full && q_stat.empty))
  // A queued descriptor fills an empty output stage on the next cycle
  `JSE_ASSERT_NEXT(a_fall_through, q_valid && !m_axis_tvalid_o, m_axis_tvalid_o)

endmodule
